// ----- rtl/dsp2_pkg.sv -----
// Package with shared constants and stage payload types for the binary64 scale unit.
package dsp2_pkg;

  localparam int unsigned FracW   = 52;
  localparam int unsigned ExpW    = 11;
  localparam int unsigned ScaleW  = 13;
  localparam int unsigned WordW   = 64;
  localparam logic [ExpW-1:0] ExpAllOnes = 11'h7FF;

  // Payload after the decode and normalize-count stage.
  typedef struct packed {
    logic              bypass;
    logic [WordW-1:0]  raw;
    logic              sign;
    logic [FracW:0]    mant;     // significand, not yet normalized
    logic [5:0]        lz;       // normalizing left shift
    logic signed [14:0] ex;      // biased exponent before normalization
    logic signed [ScaleW-1:0] scale;
  } dec_t;

  // Payload after the normalize and exponent-add stage.
  typedef struct packed {
    logic              bypass;
    logic [WordW-1:0]  raw;
    logic              sign;
    logic [FracW:0]    mant;
    logic signed [14:0] ne;
  } nrm_t;

  // Payload after the denormalizing shift stage.
  typedef struct packed {
    logic              done;     // result already final
    logic [WordW-1:0]  res;
    logic              err;
    logic              sign;
    logic [FracW:0]    q;
    logic              guard;
    logic              sticky;
  } shf_t;

endpackage

// ----- rtl/double_scale_by_power_of_two_top.sv -----
// Top level of the pipelined binary64 power-of-two scale unit.
//
//  channel | valid   | stall   | payload
//  in      | valid_i | stall_o | value_bits_i, scale_i
//  out     | valid_o | stall_i | result_bits_o, range_error_o
//
// One word enters per cycle while stall_o is low and passes the four register stages
// (decode with leading-zero count, normalize and exponent add, denormalizing shift,
// round). The stall from the output freezes every full stage with no empty stage after
// it, so no word is lost. Reset clears only the stage valid bits. stall_o is stall_i
// when all four stages hold a word, and low otherwise, so bubbles are squeezed out.
module double_scale_by_power_of_two_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] value_bits_i,
  input  logic signed [12:0] scale_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] result_bits_o,
  output logic        range_error_o
);

  logic [3:0] vld_q;
  logic [3:0] adv;
  dsp2_pkg::dec_t s1_q, s1_d;
  dsp2_pkg::nrm_t s2_q, s2_d;
  dsp2_pkg::shf_t s3_q, s3_d;
  logic [63:0] res_q, res_d;
  logic err_q, err_d;

  // A stage moves when the stage after it moves or is empty.
  assign adv[3] = !vld_q[3] || !stall_i;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign stall_o = !adv[0];

  // Stage 1: decode fields and count leading zeros of a subnormal fraction.
  always_comb begin
    logic [10:0] e;
    logic [51:0] f;
    s1_d = '0;
    e = value_bits_i[62:52];
    f = value_bits_i[51:0];
    s1_d.raw    = value_bits_i;
    s1_d.sign   = value_bits_i[63];
    s1_d.scale  = scale_i;
    s1_d.bypass = (scale_i == '0) || (e == dsp2_pkg::ExpAllOnes) || (e == '0 && f == '0);
    s1_d.lz     = '0;
    if (e != '0) begin
      s1_d.mant = {1'b1, f};
      s1_d.ex   = 15'(e);
    end else begin
      s1_d.mant = {1'b0, f};
      s1_d.ex   = 15'sd1;
      for (int i = 0; i < 52; i++) begin
        if (f[i]) s1_d.lz = 6'(52 - i);
      end
    end
  end

  // Stage 2: normalize and add the scale.
  always_comb begin
    s2_d.bypass = s1_q.bypass;
    s2_d.raw    = s1_q.raw;
    s2_d.sign   = s1_q.sign;
    s2_d.mant   = s1_q.mant << s1_q.lz;
    s2_d.ne     = s1_q.ex - 15'(s1_q.lz) + 15'(s1_q.scale);
  end

  // Stage 3: bypass pass-through, overflow, normal packing, or right shift for underflow.
  always_comb begin
    logic [6:0]   sh;
    logic [107:0] wide;
    s3_d = '0;
    sh = '0;
    wide = '0;
    s3_d.sign = s2_q.sign;
    if (s2_q.bypass) begin
      s3_d.done = 1'b1;
      s3_d.res  = s2_q.raw;
    end else if (s2_q.ne >= 15'sd2047) begin
      s3_d.done = 1'b1;
      s3_d.res  = {s2_q.sign, dsp2_pkg::ExpAllOnes, 52'd0};
      s3_d.err  = 1'b1;
    end else if (s2_q.ne >= 15'sd1) begin
      s3_d.done = 1'b1;
      s3_d.res  = {s2_q.sign, s2_q.ne[10:0], s2_q.mant[51:0]};
    end else begin
      if (s2_q.ne < -15'sd53) sh = 7'd54;
      else sh = 7'(15'sd1 - s2_q.ne);
      wide = {s2_q.mant, 55'd0} >> sh;
      s3_d.q      = wide[107:55];
      s3_d.guard  = wide[54];
      s3_d.sticky = |wide[53:0];
    end
  end

  // Stage 4: round to nearest even.
  always_comb begin
    logic up;
    up = s3_q.guard && (s3_q.sticky || s3_q.q[0]);
    if (s3_q.done) begin
      res_d = s3_q.res;
      err_d = s3_q.err;
    end else begin
      res_d = {s3_q.sign, 63'(s3_q.q) + 63'(up)};
      err_d = s3_q.guard || s3_q.sticky;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
    if (adv[3]) begin
      res_q <= res_d;
      err_q <= err_d;
    end
  end

  assign valid_o       = vld_q[3];
  assign result_bits_o = res_q;
  assign range_error_o = err_q;

  // A stalled output word holds its value and flag.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(result_bits_o) && $stable(range_error_o))
    else $error("output word changed under stall");

  // Input is only held back when the pipe is full.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (vld_q == 4'hF) && stall_i)
    else $error("input stalled with room in the pipe");

  // A flagged result with an all-ones exponent is an infinity, never a NaN.
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && range_error_o && result_bits_o[62:52] == dsp2_pkg::ExpAllOnes
      |-> result_bits_o[51:0] == '0)
    else $error("overflow result is not an infinity");

endmodule

// ----- bench/double_scale_by_power_of_two_top_test.sv -----
// Testbench for the pipelined binary64 power-of-two scale unit.
module double_scale_by_power_of_two_top_test;

  localparam int NumRandom = 730;
  localparam int WatchLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [63:0] value_bits_i = '0;
  logic signed [12:0] scale_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [63:0] result_bits_o;
  logic        range_error_o;

  typedef struct {
    logic [63:0] bits;
    logic        err;
  } scaled_t;

  typedef struct {
    logic [63:0] bits;
    logic signed [12:0] scale;
    logic        known;
    logic [63:0] exp_bits;
    logic        exp_err;
  } row_t;

  scaled_t expected_words[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;
  row_t rows[$];

  double_scale_by_power_of_two_top DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scale one binary64 word by two to the given power, round to nearest even.
  function automatic scaled_t scale_double(logic [63:0] v, logic signed [12:0] s);
    scaled_t r;
    logic [63:0] sign;
    logic [10:0] e;
    logic [51:0] f;
    logic [63:0] m, q, rem, half;
    int ex, ne, sh;
    sign = v & 64'h8000_0000_0000_0000;
    e = v[62:52];
    f = v[51:0];
    r.err = 1'b0;
    if (s == 0 || e == 11'h7FF || (e == 0 && f == 0)) begin
      r.bits = v;
      return r;
    end
    if (e != 0) begin
      m = {11'd0, 1'b1, f};
      ex = e;
    end else begin
      m = {12'd0, f};
      sh = 0;
      while (m[52] == 1'b0) begin
        m = m << 1;
        sh++;
      end
      ex = 1 - sh;
    end
    ne = ex + int'(s);
    if (ne >= 2047) begin
      r.bits = sign | {1'b0, 11'h7FF, 52'd0};
      r.err = 1'b1;
    end else if (ne >= 1) begin
      r.bits = sign | (64'(ne) << 52) | {12'd0, m[51:0]};
    end else begin
      sh = 1 - ne;
      if (sh > 54) sh = 54;
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      r.err = (rem != 0);
      r.bits = sign | q;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic add_row(logic [63:0] b, logic signed [12:0] s, logic k = 0,
                         logic [63:0] eb = 0, logic ee = 0);
    row_t r;
    r.bits = b; r.scale = s; r.known = k; r.exp_bits = eb; r.exp_err = ee;
    rows.push_back(r);
  endtask

  // Random operand: biased toward subnormals, edges of range, and specials.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v[62:52] = 11'd0;
      1: v[62:52] = 11'h7FF;
      2: v[62:52] = 11'($urandom_range(0, 60));
      3: v[62:52] = 11'($urandom_range(1990, 2046));
      4: v[51:0] = $urandom_range(0, 3) == 0 ? 52'd0 : v[51:0];
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [12:0] rand_scale();
    case ($urandom_range(0, 3))
      0: return 13'($urandom_range(0, 8191));
      1: return 13'(int'($urandom_range(0, 140)) - 70);
      2: return 13'(int'($urandom_range(0, 200)) - 1100);
      default: return 13'(int'($urandom_range(0, 200)) + 950);
    endcase
  endfunction

  // Sender: offers each word with a random gap (none for words 101 to 249), holding it while stalled.
  initial begin
    int gap;
    int n;
    add_row(64'h3FF0_0000_0000_0000, 13'sd0, 1, 64'h3FF0_0000_0000_0000, 0);
    add_row(64'h8000_0000_0000_0000, 13'sd5, 1, 64'h8000_0000_0000_0000, 0);
    add_row(64'h0000_0000_0000_0000, 13'sh1000, 1, 64'h0, 0);
    add_row(64'h7FF0_0000_0000_0000, -13'sd7, 1, 64'h7FF0_0000_0000_0000, 0);
    add_row(64'h7FF0_0000_0000_0001, 13'sd3, 1, 64'h7FF0_0000_0000_0001, 0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 13'sd9, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add_row(64'h3FF0_0000_0000_0000, 13'sd4095, 1, 64'h7FF0_0000_0000_0000, 1);
    add_row(64'hBFF0_0000_0000_0000, 13'sd1024, 1, 64'hFFF0_0000_0000_0000, 1);
    add_row(64'h3FF0_0000_0000_0000, 13'sh1000, 1, 64'h0, 1);
    add_row(64'hBFF0_0000_0000_0000, -13'sd1074, 1, 64'h8000_0000_0000_0001, 0);
    add_row(64'h3FF0_0000_0000_0000, -13'sd1075, 1, 64'h0, 1);
    add_row(64'h0000_0000_0000_0001, 13'sd1, 1, 64'h2, 0);
    add_row(64'h0000_0000_0000_0001, 13'sd1074, 1, 64'h3FF0_0000_0000_0000, 0);
    add_row(64'h0000_0000_0000_0003, -13'sd1, 1, 64'h2, 1);
    add_row(64'h000F_FFFF_FFFF_FFFF, 13'sd1, 0);
    add_row(64'h001F_FFFF_FFFF_FFFF, -13'sd1, 0);
    add_row(64'h7FEF_FFFF_FFFF_FFFF, 13'sd1, 0);
    add_row(64'h7FEF_FFFF_FFFF_FFFF, -13'sd2046, 0);
    add_row(64'h0000_0000_0000_0005, -13'sd1, 0);
    add_row(64'h4000_0000_0000_0000, -13'sd1, 0);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    n = rows.size() + NumRandom;
    for (int i = 0; i < n; i++) begin
      row_t r;
      if (i < rows.size()) r = rows[i];
      else begin
        r.bits = rand_value(); r.scale = rand_scale(); r.known = 0;
      end
      gap = (i > 100 && i < 250) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      valid_i <= 1'b1;
      value_bits_i <= r.bits;
      scale_i <= r.scale;
      begin
        scaled_t w;
        w = scale_double(r.bits, r.scale);
        if (r.known && (w.bits !== r.exp_bits || w.err !== r.exp_err))
          report_mismatch("table", w.bits, r.exp_bits);
        if (r.known) begin
          w.bits = r.exp_bits; w.err = r.exp_err;
        end
        expected_words.push_back(w);
      end
      @(posedge clk_i);
      while (stall_o) @(posedge clk_i);
      words_in++;
      @(negedge clk_i);
    end
    valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls once 100 words are in, with one long hold-off to fill the pipe.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (words_in >= 300 && hold_off == 0) begin
        stall_i <= 1'b1;
        for (hold_off = 0; hold_off < 40; hold_off++) @(negedge clk_i);
      end
      wait_n = (words_in < 100) ? 0 : $urandom_range(0, 3);
      if (wait_n > 0) begin
        stall_i <= 1'b1;
        repeat (wait_n - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      stall_i <= 1'b0;
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      words_out++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", result_bits_o, 64'd0);
      end else begin
        scaled_t w;
        w = expected_words.pop_front();
        if (result_bits_o !== w.bits) report_mismatch("result_bits", result_bits_o, w.bits);
        if (range_error_o !== w.err)
          report_mismatch("range_error", 64'(range_error_o), 64'(w.err));
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("double_scale_by_power_of_two_top verification failed");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (expected_words.size() == 0);
    repeat (10) @(posedge clk_i);
    if (expected_words.size() != 0) errors++;
    $display("Sent %0d words (directed specials, overflow, underflow, random), checked %0d.",
             words_in, words_out);
    if (errors == 0) begin
      $display("double_scale_by_power_of_two_top verification clean");
    end else begin
      $display("double_scale_by_power_of_two_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dsp2_pkg.sv
rtl/double_scale_by_power_of_two_top.sv
bench/double_scale_by_power_of_two_top_test.sv
